// ----- hdl/lpmd_pkg.sv -----
// Shared types, widths, register codes and helpers for the pendulum motor drive.
package lpmd_pkg;

  // Multiplier operand and product widths
  localparam int OPA_W  = 25;
  localparam int OPB_W  = 22;
  localparam int PROD_W = OPA_W + OPB_W;

  // Accumulator holds the Q26 feedback and force sums with headroom
  localparam int ACC_W  = 61;

  // Full precision rate, voltage and sample widths
  localparam int SAMP_W = 18;
  localparam int DIFF_W = SAMP_W + 1;
  localparam int RATE_W = 35;
  localparam int VOLT_W = 21;
  localparam int LIM_W  = 20;
  localparam int GAIN_W = 24;
  localparam int INV_W  = 16;
  localparam int K2F_W  = 23;
  localparam int DATA_W = 24;
  localparam int IDX_W  = 4;
  localparam int OUT_W  = 32;

  // Split of a rate into a low unsigned part and a high signed part
  localparam int HI_SHIFT = 21;

  // Q26 to Q12 rounding: add half, drop fourteen bits
  localparam int FRAC_DROP = 14;
  localparam int RND_W     = ACC_W - FRAC_DROP;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (FRAC_DROP - 1));

  // Register indexes
  localparam logic [IDX_W-1:0] REG_GAIN_POSITION   = 4'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_ANGLE      = 4'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_CART_RATE  = 4'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_ANGLE_RATE = 4'd3;
  localparam logic [IDX_W-1:0] REG_INVERSE_PERIOD  = 4'd4;
  localparam logic [IDX_W-1:0] REG_VOLT_LIMIT      = 4'd5;
  localparam logic [IDX_W-1:0] REG_VOLT_TO_FORCE   = 4'd6;
  localparam logic [IDX_W-1:0] REG_RATE_TO_FORCE   = 4'd7;

  // Accumulator operation applied when a product lands
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  // Left shift of a product before it is accumulated
  typedef enum logic [1:0] {
    SH_NONE,
    SH_FOUR,
    SH_HIGH
  } shift_t;

  typedef struct packed {
    acc_op_t                  op;
    shift_t                   shift;
    logic signed [OPA_W-1:0]  a;
    logic signed [OPB_W-1:0]  b;
  } mac_cmd_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_position;
    logic signed [GAIN_W-1:0] gain_angle;
    logic signed [GAIN_W-1:0] gain_cart_rate;
    logic signed [GAIN_W-1:0] gain_angle_rate;
    logic [INV_W-1:0]         inverse_period;
    logic [LIM_W-1:0]         volt_limit;
    logic [K2F_W-1:0]         volt_to_force;
    logic [K2F_W-1:0]         rate_to_force;
  } cfg_t;

  // Saturate a rounded value to 32 bits signed
  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] hi;
    logic signed [RND_W-1:0] lo;
    hi = RND_W'(64'sd2147483647);
    lo = RND_W'(-64'sd2147483648);
    if (v > hi) begin
      sat32 = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (v < lo) begin
      sat32 = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat32 = v[OUT_W-1:0];
    end
  endfunction

endpackage

// ----- hdl/lpmd_cfg.sv -----
// Configuration register file for gains, sample rate, clip level and force constants.
module lpmd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [lpmd_pkg::IDX_W-1:0]  wr_index,
  input  logic [lpmd_pkg::DATA_W-1:0] wr_data,
  output lpmd_pkg::cfg_t              cfg
);
  import lpmd_pkg::*;

  // Load reset values, then take writes to known indexes and drop the rest
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_position   <= -24'sd1238514;
      cfg.gain_angle      <= 24'sd3481815;
      cfg.gain_cart_rate  <= -24'sd1041342;
      cfg.gain_angle_rate <= 24'sd317812;
      cfg.inverse_period  <= 16'd100;
      cfg.volt_limit      <= 20'd49152;
      cfg.volt_to_force   <= 23'd1693;
      cfg.rate_to_force   <= 23'd8747;
    end else if (wr_en) begin
      case (wr_index)
        REG_GAIN_POSITION:   cfg.gain_position   <= wr_data[GAIN_W-1:0];
        REG_GAIN_ANGLE:      cfg.gain_angle      <= wr_data[GAIN_W-1:0];
        REG_GAIN_CART_RATE:  cfg.gain_cart_rate  <= wr_data[GAIN_W-1:0];
        REG_GAIN_ANGLE_RATE: cfg.gain_angle_rate <= wr_data[GAIN_W-1:0];
        REG_INVERSE_PERIOD:  cfg.inverse_period  <= wr_data[INV_W-1:0];
        REG_VOLT_LIMIT:      cfg.volt_limit      <= wr_data[LIM_W-1:0];
        REG_VOLT_TO_FORCE:   cfg.volt_to_force   <= wr_data[K2F_W-1:0];
        REG_RATE_TO_FORCE:   cfg.rate_to_force   <= wr_data[K2F_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/lpmd_mac.sv -----
// Shared signed multiplier with a registered product and a shifting accumulator.
module lpmd_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  lpmd_pkg::mac_cmd_t                  cmd,
  output logic signed [lpmd_pkg::PROD_W-1:0]  prod,
  output logic signed [lpmd_pkg::ACC_W-1:0]   acc
);
  import lpmd_pkg::*;

  acc_op_t                  op_d;
  shift_t                   shift_d;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  term;

  // Multiply stage: register the product and its accumulate command
  always_ff @(posedge clk) begin
    prod    <= cmd.a * cmd.b;
    shift_d <= cmd.shift;
    if (rst) begin
      op_d <= ACC_NONE;
    end else begin
      op_d <= cmd.op;
    end
  end

  // Align the product for the accumulator
  always_comb begin
    prod_ext = ACC_W'(prod);
    case (shift_d)
      SH_NONE: term = prod_ext;
      SH_FOUR: term = prod_ext <<< 2;
      SH_HIGH: term = prod_ext <<< HI_SHIFT;
      default: term = prod_ext;
    endcase
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    case (op_d)
      ACC_LOAD: acc <= term;
      ACC_ADD:  acc <= acc + term;
      ACC_SUB:  acc <= acc - term;
      default:  acc <= acc;
    endcase
  end

endmodule

// ----- hdl/lqr_pendulum_motor_drive.sv -----
// LQR state-feedback motor drive: rates, clipped voltage and drive force per sample.
// A new word is taken only in the idle step, once the previous result is registered; the
// single shared multiplier issues eleven products in sequence (two rates, four feedback terms
// with split rate operands, three force terms), plus rounding, clipping, pipeline drain,
// output and idle steps.
// Reset: synchronous; config, sequencer and out_valid reset, previous samples to zero.
module lqr_pendulum_motor_drive (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lpmd_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lpmd_pkg::DATA_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [17:0]          cart_position,
  input  logic signed [17:0]          pole_angle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          drive_force,
  output logic signed [20:0]          motor_voltage,
  output logic                        voltage_clipped,
  output logic signed [31:0]          cart_rate,
  output logic signed [31:0]          angle_rate
);
  import lpmd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_VX,
    ST_MUL_VA,
    ST_KP,
    ST_KA,
    ST_KV_LO,
    ST_KV_HI,
    ST_KW_LO,
    ST_KW_HI,
    ST_DRAIN_V,
    ST_ROUND_V,
    ST_CLIP,
    ST_F_VOLT,
    ST_F_LO,
    ST_F_HI,
    ST_DRAIN_F,
    ST_OUT
  } state_t;

  state_t                    state;
  cfg_t                      cfg;
  mac_cmd_t                  cmd;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [ACC_W-1:0]   neg_rnd;

  logic signed [SAMP_W-1:0]  prev_x;
  logic signed [SAMP_W-1:0]  prev_a;
  logic signed [SAMP_W-1:0]  x_s;
  logic signed [SAMP_W-1:0]  a_s;
  logic signed [DIFF_W-1:0]  dx;
  logic signed [DIFF_W-1:0]  da;
  logic signed [RATE_W-1:0]  vx;
  logic signed [RATE_W-1:0]  va;
  logic signed [RND_W-1:0]   vround;
  logic signed [VOLT_W-1:0]  volt;
  logic                      clipped;
  logic signed [RND_W-1:0]   lim_s;
  logic                      out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign acc_rnd   = acc + RND_HALF;
  assign neg_rnd   = RND_HALF - acc;
  assign lim_s     = RND_W'({1'b0, cfg.volt_limit});

  lpmd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lpmd_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .prod (prod),
    .acc  (acc)
  );

  // Select multiplier operands and accumulate command for each step
  always_comb begin
    cmd.op    = ACC_NONE;
    cmd.shift = SH_NONE;
    cmd.a     = '0;
    cmd.b     = '0;
    case (state)
      ST_MUL_VX: begin
        cmd.a = OPA_W'({1'b0, cfg.inverse_period});
        cmd.b = OPB_W'(dx);
      end
      ST_MUL_VA: begin
        cmd.a = OPA_W'({1'b0, cfg.inverse_period});
        cmd.b = OPB_W'(da);
      end
      ST_KP: begin
        cmd.op = ACC_LOAD;
        cmd.a  = OPA_W'(cfg.gain_position);
        cmd.b  = OPB_W'(x_s);
      end
      ST_KA: begin
        cmd.op = ACC_ADD;
        cmd.a  = OPA_W'(cfg.gain_angle);
        cmd.b  = OPB_W'(a_s);
      end
      ST_KV_LO: begin
        cmd.op = ACC_ADD;
        cmd.a  = OPA_W'(cfg.gain_cart_rate);
        cmd.b  = {1'b0, vx[HI_SHIFT-1:0]};
      end
      ST_KV_HI: begin
        cmd.op    = ACC_ADD;
        cmd.shift = SH_HIGH;
        cmd.a     = OPA_W'(cfg.gain_cart_rate);
        cmd.b     = OPB_W'($signed(vx[RATE_W-1:HI_SHIFT]));
      end
      ST_KW_LO: begin
        cmd.op = ACC_ADD;
        cmd.a  = OPA_W'(cfg.gain_angle_rate);
        cmd.b  = {1'b0, va[HI_SHIFT-1:0]};
      end
      ST_KW_HI: begin
        cmd.op    = ACC_ADD;
        cmd.shift = SH_HIGH;
        cmd.a     = OPA_W'(cfg.gain_angle_rate);
        cmd.b     = OPB_W'($signed(va[RATE_W-1:HI_SHIFT]));
      end
      ST_F_VOLT: begin
        cmd.op    = ACC_LOAD;
        cmd.shift = SH_FOUR;
        cmd.a     = OPA_W'({1'b0, cfg.volt_to_force});
        cmd.b     = OPB_W'(volt);
      end
      ST_F_LO: begin
        cmd.op = ACC_SUB;
        cmd.a  = OPA_W'({1'b0, cfg.rate_to_force});
        cmd.b  = {1'b0, vx[HI_SHIFT-1:0]};
      end
      ST_F_HI: begin
        cmd.op    = ACC_SUB;
        cmd.shift = SH_HIGH;
        cmd.a     = OPA_W'({1'b0, cfg.rate_to_force});
        cmd.b     = OPB_W'($signed(vx[RATE_W-1:HI_SHIFT]));
      end
      default: ;
    endcase
  end

  // Sequencer, sample history and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      prev_x    <= '0;
      prev_a    <= '0;
    end else begin
      if (out_valid && out_ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            x_s    <= cart_position;
            a_s    <= pole_angle;
            dx     <= DIFF_W'(cart_position) - DIFF_W'(prev_x);
            da     <= DIFF_W'(pole_angle) - DIFF_W'(prev_a);
            prev_x <= cart_position;
            prev_a <= pole_angle;
            state  <= ST_MUL_VX;
          end
        end
        ST_MUL_VX:  state <= ST_MUL_VA;
        ST_MUL_VA: begin
          vx    <= prod[RATE_W-1:0];
          state <= ST_KP;
        end
        ST_KP: begin
          va    <= prod[RATE_W-1:0];
          state <= ST_KA;
        end
        ST_KA:      state <= ST_KV_LO;
        ST_KV_LO:   state <= ST_KV_HI;
        ST_KV_HI:   state <= ST_KW_LO;
        ST_KW_LO:   state <= ST_KW_HI;
        ST_KW_HI:   state <= ST_DRAIN_V;
        ST_DRAIN_V: state <= ST_ROUND_V;
        ST_ROUND_V: begin
          // Accumulator holds +sum; voltage is the rounded negation
          vround <= neg_rnd[ACC_W-1:FRAC_DROP];
          state  <= ST_CLIP;
        end
        ST_CLIP: begin
          if (vround > lim_s) begin
            volt    <= VOLT_W'(lim_s);
            clipped <= 1'b1;
          end else if (vround < -lim_s) begin
            volt    <= VOLT_W'(-lim_s);
            clipped <= 1'b1;
          end else begin
            volt    <= vround[VOLT_W-1:0];
            clipped <= 1'b0;
          end
          state <= ST_F_VOLT;
        end
        ST_F_VOLT:  state <= ST_F_LO;
        ST_F_LO:    state <= ST_F_HI;
        ST_F_HI:    state <= ST_DRAIN_F;
        ST_DRAIN_F: state <= ST_OUT;
        ST_OUT: begin
          // Hold until the output register is free
          if (out_free) begin
            drive_force     <= sat32(acc_rnd[ACC_W-1:FRAC_DROP]);
            motor_voltage   <= volt;
            voltage_clipped <= clipped;
            cart_rate       <= sat32(RND_W'(vx));
            angle_rate      <= sat32(RND_W'(va));
            out_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> (state == ST_MUL_VX))
    else $error("accepted word did not start the sequence");

  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_OUT))
    else $error("result word raised outside the output step");

  a_clip_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && voltage_clipped) |->
      ((motor_voltage == VOLT_W'({1'b0, cfg.volt_limit})) ||
       (motor_voltage == -VOLT_W'({1'b0, cfg.volt_limit}))))
    else $error("clipped voltage not at the limit");

  a_within_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !voltage_clipped) |->
      ((motor_voltage <= $signed({2'b00, cfg.volt_limit})) &&
       (motor_voltage >= -$signed({2'b00, cfg.volt_limit}))))
    else $error("unclipped voltage beyond the limit");
`endif

endmodule

// ----- tb/sv/lqr_pendulum_motor_drive_test.sv -----
// Self-checking testbench for the pendulum motor drive: directed table, random phases, predictor.
module lqr_pendulum_motor_drive_test;
  import lpmd_pkg::*;

  // Unused register codes: writes to these must leave the block unchanged
  localparam logic [IDX_W-1:0] REG_UNUSED_LOW  = 4'd8;
  localparam logic [IDX_W-1:0] REG_UNUSED_HIGH = 4'd15;

  localparam logic signed [SAMP_W-1:0] SAMPLE_MIN = 18'sh20000;
  localparam logic signed [SAMP_W-1:0] SAMPLE_MAX = 18'sh1FFFF;

  localparam longint ROUND_HALF = 64'sd8192;
  localparam int     FRAC_SHIFT = 14;

  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 30;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASE_COUNT     = 8;
  localparam int ITEMS_PER_PHASE = 194;
  localparam int PRESSURE_PHASE  = 4;

  localparam logic [DATA_W-1:0] RESET_WORD [8] = '{
    24'(-1238514), 24'd3481815, 24'(-1041342), 24'd317812,
    24'd100, 24'd49152, 24'd1693, 24'd8747
  };

  typedef struct packed {
    logic signed [OUT_W-1:0]  drive_force;
    logic signed [VOLT_W-1:0] motor_voltage;
    logic                     voltage_clipped;
    logic signed [OUT_W-1:0]  cart_rate;
    logic signed [OUT_W-1:0]  angle_rate;
  } drive_result_t;

  localparam drive_result_t ALL_ZERO     = '0;
  localparam drive_result_t ZERO_CLIPPED = '{32'sd0, 21'sd0, 1'b1, 32'sd0, 32'sd0};
  localparam drive_result_t AT_LIMIT     = '{32'sd1000, 21'sd1000, 1'b0, 32'sd100000, 32'sd0};
  localparam drive_result_t OVER_LIMIT   = '{32'sd1000, 21'sd1000, 1'b1, 32'sd100, 32'sd0};

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [IDX_W-1:0]         index;
    logic [DATA_W-1:0]        data;
    logic signed [SAMP_W-1:0] x;
    logic signed [SAMP_W-1:0] a;
    drive_result_t            known;
  } row_t;

  typedef enum logic [1:0] {SET_DEFAULTS, SET_GENTLE, SET_RANDOM, SET_EXTREME} setting_mode_t;

  // Directed rows: extremes, zero period, zero limit, clip boundary, unused codes
  localparam row_t DIRECTED [42] = '{
    '{ROW_KNOWN,  REG_GAIN_POSITION,   24'd0, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_SAMPLE, REG_GAIN_POSITION,   24'd0, SAMPLE_MAX, SAMPLE_MIN, ALL_ZERO},
    '{ROW_SAMPLE, REG_GAIN_POSITION,   24'd0, SAMPLE_MIN, SAMPLE_MAX, ALL_ZERO},
    '{ROW_SAMPLE, REG_GAIN_POSITION,   24'd0, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_INVERSE_PERIOD,  24'd0, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_VOLT_LIMIT,      24'd0, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_KNOWN,  REG_GAIN_POSITION,   24'd0, SAMPLE_MAX, 18'sd0, ZERO_CLIPPED},
    '{ROW_KNOWN,  REG_GAIN_POSITION,   24'd0, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_GAIN_POSITION,   24'h7FFFFF, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_GAIN_ANGLE,      24'h800000, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_GAIN_CART_RATE,  24'h7FFFFF, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_GAIN_ANGLE_RATE, 24'h800000, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_INVERSE_PERIOD,  24'h00FFFF, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_VOLT_LIMIT,      24'h0FFFFF, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_VOLT_TO_FORCE,   24'h7FFFFF, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_RATE_TO_FORCE,   24'h7FFFFF, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_SAMPLE, REG_GAIN_POSITION,   24'd0, SAMPLE_MAX, SAMPLE_MIN, ALL_ZERO},
    '{ROW_SAMPLE, REG_GAIN_POSITION,   24'd0, SAMPLE_MIN, SAMPLE_MAX, ALL_ZERO},
    '{ROW_SAMPLE, REG_GAIN_POSITION,   24'd0, SAMPLE_MAX, SAMPLE_MAX, ALL_ZERO},
    '{ROW_SAMPLE, REG_GAIN_POSITION,   24'd0, -18'sd1, 18'sd1, ALL_ZERO},
    '{ROW_WRITE,  REG_GAIN_POSITION,   24'h800000, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_GAIN_ANGLE,      24'h7FFFFF, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_GAIN_CART_RATE,  24'h800000, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_GAIN_ANGLE_RATE, 24'h7FFFFF, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_SAMPLE, REG_GAIN_POSITION,   24'd0, SAMPLE_MIN, SAMPLE_MIN, ALL_ZERO},
    '{ROW_SAMPLE, REG_GAIN_POSITION,   24'd0, SAMPLE_MAX, SAMPLE_MAX, ALL_ZERO},
    '{ROW_SAMPLE, REG_GAIN_POSITION,   24'd0, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_GAIN_POSITION,   24'hFFC000, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_GAIN_ANGLE,      24'd0, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_GAIN_CART_RATE,  24'd0, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_GAIN_ANGLE_RATE, 24'd0, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_INVERSE_PERIOD,  24'hFF0064, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_VOLT_LIMIT,      24'd1000, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_VOLT_TO_FORCE,   24'd4096, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_RATE_TO_FORCE,   24'd0, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_UNUSED_LOW,      24'hFFFFFF, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_WRITE,  REG_UNUSED_HIGH,     24'hFFFFFF, 18'sd0, 18'sd0, ALL_ZERO},
    '{ROW_KNOWN,  REG_GAIN_POSITION,   24'd0, 18'sd1000, 18'sd0, AT_LIMIT},
    '{ROW_KNOWN,  REG_GAIN_POSITION,   24'd0, 18'sd1001, 18'sd0, OVER_LIMIT},
    '{ROW_SAMPLE, REG_GAIN_POSITION,   24'd0, -18'sd1000, 18'sd0, ALL_ZERO},
    '{ROW_SAMPLE, REG_GAIN_POSITION,   24'd0, -18'sd1001, 18'sd0, ALL_ZERO},
    '{ROW_SAMPLE, REG_GAIN_POSITION,   24'd0, 18'sd0, 18'sd5, ALL_ZERO}
  };

  localparam int SEND_IDLE_PCT [4]  = '{0, 56, 0, 17};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 56, 17};
  localparam setting_mode_t PHASE_MODE [PHASE_COUNT] = '{
    SET_DEFAULTS, SET_GENTLE, SET_RANDOM, SET_GENTLE,
    SET_EXTREME, SET_GENTLE, SET_RANDOM, SET_GENTLE
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMP_W-1:0] cart_position = '0;
  logic signed [SAMP_W-1:0] pole_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] drive_force;
  logic signed [VOLT_W-1:0] motor_voltage;
  logic voltage_clipped;
  logic signed [OUT_W-1:0] cart_rate;
  logic signed [OUT_W-1:0] angle_rate;

  // Predictor state: register copy and previous samples
  cfg_t model_cfg;
  logic signed [SAMP_W-1:0] prev_cart;
  logic signed [SAMP_W-1:0] prev_angle;

  drive_result_t drive_results_due [$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_token = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  lqr_pendulum_motor_drive uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cart_position(cart_position), .pole_angle(pole_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .drive_force(drive_force), .motor_voltage(motor_voltage),
    .voltage_clipped(voltage_clipped), .cart_rate(cart_rate), .angle_rate(angle_rate)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mirror a register write; unknown codes and bits above the width drop out
  function automatic void model_write(input logic [IDX_W-1:0] index,
                                      input logic [DATA_W-1:0] data);
    case (index)
      REG_GAIN_POSITION:   model_cfg.gain_position   = data[GAIN_W-1:0];
      REG_GAIN_ANGLE:      model_cfg.gain_angle      = data[GAIN_W-1:0];
      REG_GAIN_CART_RATE:  model_cfg.gain_cart_rate  = data[GAIN_W-1:0];
      REG_GAIN_ANGLE_RATE: model_cfg.gain_angle_rate = data[GAIN_W-1:0];
      REG_INVERSE_PERIOD:  model_cfg.inverse_period  = data[INV_W-1:0];
      REG_VOLT_LIMIT:      model_cfg.volt_limit      = data[LIM_W-1:0];
      REG_VOLT_TO_FORCE:   model_cfg.volt_to_force   = data[K2F_W-1:0];
      REG_RATE_TO_FORCE:   model_cfg.rate_to_force   = data[K2F_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_word(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return OUT_W'(v);
  endfunction

  // Rates, clipped voltage and force for one sample; advance the previous samples
  function automatic drive_result_t predict_drive(input logic signed [SAMP_W-1:0] x,
                                                  input logic signed [SAMP_W-1:0] a);
    longint vx, va, sum, volt, lim, drive_sum;
    drive_result_t r;
    vx = (longint'(x) - longint'(prev_cart)) * longint'(model_cfg.inverse_period);
    va = (longint'(a) - longint'(prev_angle)) * longint'(model_cfg.inverse_period);
    sum = longint'(model_cfg.gain_position) * longint'(x)
        + longint'(model_cfg.gain_angle) * longint'(a)
        + longint'(model_cfg.gain_cart_rate) * vx
        + longint'(model_cfg.gain_angle_rate) * va;
    volt = (ROUND_HALF - sum) >>> FRAC_SHIFT;
    lim = longint'(model_cfg.volt_limit);
    r.voltage_clipped = 1'b0;
    if (volt > lim) begin
      volt = lim;
      r.voltage_clipped = 1'b1;
    end else if (volt < -lim) begin
      volt = -lim;
      r.voltage_clipped = 1'b1;
    end
    drive_sum = 4 * longint'(model_cfg.volt_to_force) * volt
              - longint'(model_cfg.rate_to_force) * vx;
    r.drive_force = clamp_word((drive_sum + ROUND_HALF) >>> FRAC_SHIFT);
    r.motor_voltage = VOLT_W'(volt);
    r.cart_rate = clamp_word(vx);
    r.angle_rate = clamp_word(va);
    prev_cart = x;
    prev_angle = a;
    return r;
  endfunction

  // Mostly small steps from the last sample, some rail values, some anywhere
  function automatic logic signed [SAMP_W-1:0] next_sample(input logic signed [SAMP_W-1:0] prev);
    int v;
    int choice;
    choice = $urandom_range(99);
    if (choice < 70) begin
      v = int'(prev) + int'($urandom_range(0, 512)) - 256;
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      return SAMP_W'(v);
    end else if (choice < 80) begin
      return ($urandom_range(1) == 1) ? SAMPLE_MAX : SAMPLE_MIN;
    end
    return SAMP_W'($urandom());
  endfunction

  // Offer one sample word, holding it until accepted, then log its expected result
  task automatic offer_sample(input logic signed [SAMP_W-1:0] x,
                              input logic signed [SAMP_W-1:0] a,
                              input logic use_known, input drive_result_t known);
    drive_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cart_position <= x;
    pole_angle <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_drive(x, a);
    drive_results_due.push_back(use_known ? known : predicted);
  endtask

  task automatic write_register(input logic [IDX_W-1:0] index, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_write(index, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every result word, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (drive_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input setting_mode_t mode);
    logic [DATA_W-1:0] word;
    for (int r = int'(REG_GAIN_POSITION); r <= int'(REG_RATE_TO_FORCE); r++) begin
      case (mode)
        SET_DEFAULTS: word = RESET_WORD[r];
        SET_RANDOM:   word = DATA_W'($urandom());
        SET_EXTREME: begin
          case ($urandom_range(3))
            0: word = '0;
            1: word = '1;
            2: word = 24'h800000;
            default: word = 24'h7FFFFF;
          endcase
        end
        default: begin
          case (IDX_W'(r))
            REG_INVERSE_PERIOD: word = DATA_W'($urandom_range(1, 200));
            REG_VOLT_LIMIT:     word = DATA_W'($urandom_range(0, 1048575));
            REG_VOLT_TO_FORCE, REG_RATE_TO_FORCE: word = DATA_W'($urandom_range(0, 16383));
            default: word = DATA_W'(int'($urandom_range(0, 262143)) - 131072);
          endcase
        end
      endcase
      write_register(IDX_W'(r), word);
    end
    write_register(REG_UNUSED_LOW + IDX_W'($urandom_range(7)), DATA_W'($urandom()));
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(input string label, input logic signed [OUT_W-1:0] want,
                                      input logic signed [OUT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    drive_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (drive_results_due.size() == 0) begin
        $display("%0t: result word with none expected, expected none actual force %0d",
                 $time, drive_force);
        mismatch_count++;
      end else begin
        want = drive_results_due.pop_front();
        check_field("drive_force", want.drive_force, drive_force);
        check_field("motor_voltage", want.motor_voltage, motor_voltage);
        check_field("voltage_clipped", {31'd0, want.voltage_clipped}, {31'd0, voltage_clipped});
        check_field("cart_rate", want.cart_rate, cart_rate);
        check_field("angle_rate", want.angle_rate, angle_rate);
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int r = int'(REG_GAIN_POSITION); r <= int'(REG_RATE_TO_FORCE); r++) begin
      model_write(IDX_W'(r), RESET_WORD[r]);
    end
    prev_cart = '0;
    prev_angle = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        settle();
        write_register(DIRECTED[i].index, DIRECTED[i].data);
      end else begin
        offer_sample(DIRECTED[i].x, DIRECTED[i].a, DIRECTED[i].kind == ROW_KNOWN,
                     DIRECTED[i].known);
      end
    end

    // Random phases, each applying a setting mode and an idling pattern
    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle();
      apply_setting(PHASE_MODE[p]);
      send_idle_pct = SEND_IDLE_PCT[p % 4];
      recv_stall_pct = RECV_STALL_PCT[p % 4];
      if (p == PRESSURE_PHASE) hold_token <= ~hold_token;
      repeat (ITEMS_PER_PHASE) begin
        offer_sample(next_sample(prev_cart), next_sample(prev_angle), 1'b0, ALL_ZERO);
      end
    end

    in_valid <= 1'b0;
    while (drive_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
